### sv/sns_pkg.sv
// Shared constants, types, logistic table builder and saturation helpers for the SGNS update block.
package sns_pkg;

    localparam int VOCAB       = 4096;
    localparam int DIM         = 128;
    localparam int SIG_ENTRIES = 1000;
    localparam int LIMIT_EXP   = 6;
    localparam int TABLE_SCALE = SIG_ENTRIES / LIMIT_EXP / 2;

    localparam int ROW_W  = (VOCAB > 1) ? $clog2(VOCAB) : 1;
    localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ADDR_W = $clog2(VOCAB * DIM);
    localparam int LUT_W  = $clog2(SIG_ENTRIES);
    localparam int DOT_W  = 33 + $clog2(DIM);
    localparam int SCL_W  = $clog2(TABLE_SCALE + 1);
    localparam int OFF_W  = 4 + 24;
    localparam int IDXP_W = OFF_W + SCL_W;
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [DOT_W-1:0] DOT_LIM = DOT_W'(LIMIT_EXP) <<< 24;

    typedef enum logic [1:0] {
        OP_TRAIN = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRITE,
        S_READ_RD,
        S_READ_DAT,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_FIN,
        S_SIG,
        S_LUT,
        S_DIFF,
        S_GRAD,
        S_U_RD,
        S_U_M1,
        S_U_M2,
        S_U_WR,
        S_A_RD,
        S_A_WR,
        S_DONE
    } t_state;

    typedef logic [15:0] t_lut_tab [SIG_ENTRIES];

    // Shift and subtract quotient, evaluated only while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned exp_neg_small(input longint unsigned r);
        longint unsigned sum;
        longint unsigned term;
        sum  = 64'd1 << 31;
        term = 64'd1 << 31;
        for (int k = 1; k <= 20; k++) begin
            term = udiv64((term * r) >> 31, 64'(k));
            if ((k & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic t_lut_tab build_logistic();
        t_lut_tab        tab;
        longint          d;
        longint unsigned mag;
        longint unsigned a;
        longint unsigned e;
        longint unsigned den;
        longint unsigned v;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            d   = 2 * longint'(i) - longint'(SIG_ENTRIES);
            mag = (d < 0) ? longint'(-d) * LIMIT_EXP : longint'(d) * LIMIT_EXP;
            a   = udiv64(mag << 31, 64'(SIG_ENTRIES));
            e   = exp_neg_small(a >> 3);
            for (int n = 0; n < 3; n++) begin
                e = (e * e) >> 31;
            end
            den = (64'd1 << 31) + e;
            if (d >= 0) begin
                v = udiv64((64'd1 << 47) + (den >> 1), den);
            end else begin
                v = udiv64((e << 16) + (den >> 1), den);
            end
            if (v > 64'd65535) begin
                v = 64'd65535;
            end
            tab[i] = v[15:0];
        end
        return tab;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        if (x > 64'sd32767) begin
            return 16'sh7FFF;
        end else if (x < -64'sd32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

### sv/sns_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module sns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/sns_mul.sv
// Shared signed multiplier with a registered product.
module sns_mul (
    input  logic                                  i_clk,
    input  logic signed [sns_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [sns_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [sns_pkg::MUL_P_W-1:0]    o_p
);

    import sns_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

endmodule

### sv/sns_lut.sv
// Logistic function ROM with a registered read.
module sns_lut (
    input  logic                        i_clk,
    input  logic [sns_pkg::LUT_W-1:0]   i_idx,
    output logic [15:0]                 o_data
);

    import sns_pkg::*;

    localparam t_lut_tab LOGISTIC = build_logistic();

    always_ff @(posedge i_clk) begin
        o_data <= LOGISTIC[i_idx];
    end

endmodule

### sv/skipgram_negative_sampling_update_top.sv
// Top level of the skip-gram negative-sampling update engine.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. Each item gives one result on o_score,
// o_gradient and o_read_data, marked by o_valid for one cycle, after which
// busy falls in the next cycle. The receiver takes every result transfer.
// A train pair runs a dot pass and an update pass, and with the
// last-of-context flag set an error vector pass as well. Its pace is set
// by the single shared multiplier and the single read port of each weight
// memory: the dot pass forms one product per element and the update pass
// two. Weights live in two single-write, single-read memories whose
// contents are undefined until written. Reset returns the sequencer to
// idle and marks the whole error vector as zero; there is no clearing
// pass.
module skipgram_negative_sampling_update_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [11:0]        i_context_row,
    input  logic [11:0]        i_target_row,
    input  logic               i_label,
    input  logic               i_last_of_context,
    input  logic [15:0]        i_learning_rate,
    input  logic               i_matrix_select,
    input  logic [6:0]         i_element_index,
    input  logic signed [15:0] i_write_value,
    output logic               o_valid,
    output logic signed [15:0] o_score,
    output logic signed [16:0] o_gradient,
    output logic signed [15:0] o_read_data
);

    import sns_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [1:0]              r_op;
    logic [ROW_W-1:0]        r_crow;
    logic [ROW_W-1:0]        r_trow;
    logic                    r_label;
    logic                    r_last;
    logic [15:0]             r_alpha;
    logic                    r_msel;
    logic [6:0]              r_el;
    logic signed [15:0]      r_wval;
    logic [IDX_W-1:0]        r_cnt;
    logic                    r_pv;
    logic signed [DOT_W-1:0] r_dot;
    logic                    r_over;
    logic                    r_under;
    logic [IDXP_W-1:0]       r_idx_prod;
    logic signed [16:0]      r_g;
    logic signed [15:0]      r_wi;
    logic signed [15:0]      r_wo;
    logic signed [31:0]      r_acc;
    logic [DIM-1:0]          r_acc_valid;
    logic                    r_acc_vld_rd;
    logic signed [15:0]      r_score;
    logic signed [16:0]      r_grad;
    logic signed [15:0]      r_rd;

    logic                    in_we;
    logic [ADDR_W-1:0]       in_waddr;
    logic [15:0]             in_wdata;
    logic [ADDR_W-1:0]       in_raddr;
    logic [15:0]             in_rdata;
    logic                    out_we;
    logic [ADDR_W-1:0]       out_waddr;
    logic [15:0]             out_wdata;
    logic [ADDR_W-1:0]       out_raddr;
    logic [15:0]             out_rdata;
    logic                    acc_we;
    logic [31:0]             acc_wdata;
    logic [31:0]             acc_rdata;
    logic signed [31:0]      acc_rd_val;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic [LUT_W-1:0]        lut_idx;
    logic [15:0]             lut_data;
    logic [IDXP_W-1:0]       idx_sh;
    logic signed [17:0]      diff;
    logic signed [17:0]      lab_term;
    logic [ADDR_W-1:0]       crow_base;
    logic [ADDR_W-1:0]       trow_base;
    logic [ADDR_W-1:0]       el_addr;
    logic [ADDR_W-1:0]       cnt_addr;
    logic                    el_ok;
    logic                    cnt_end;
    logic signed [DOT_W-1:0] dot_off;
    logic signed [MUL_P_W-1:0] g_full;

    sns_ram #(.WIDTH(16), .DEPTH(VOCAB * DIM)) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (in_wdata),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    sns_ram #(.WIDTH(16), .DEPTH(VOCAB * DIM)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (out_waddr),
        .i_wdata (out_wdata),
        .i_raddr (out_raddr),
        .o_rdata (out_rdata)
    );

    sns_ram #(.WIDTH(32), .DEPTH(DIM)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (r_cnt),
        .i_wdata (acc_wdata),
        .i_raddr (r_cnt),
        .o_rdata (acc_rdata)
    );

    sns_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    sns_lut u_lut (
        .i_clk  (i_clk),
        .i_idx  (lut_idx),
        .o_data (lut_data)
    );

    assign crow_base  = ADDR_W'(r_crow) * ADDR_W'(DIM);
    assign trow_base  = ADDR_W'(r_trow) * ADDR_W'(DIM);
    assign el_addr    = ADDR_W'(r_el);
    assign cnt_addr   = ADDR_W'(r_cnt);
    assign el_ok      = int'(r_el) < DIM;
    assign cnt_end    = r_cnt == IDX_W'(DIM - 1);
    assign acc_rd_val = r_acc_vld_rd ? $signed(acc_rdata) : 32'sd0;
    assign dot_off    = r_dot + DOT_LIM;
    assign idx_sh     = r_idx_prod >> 24;
    assign lut_idx    = (idx_sh >= IDXP_W'(SIG_ENTRIES)) ? LUT_W'(SIG_ENTRIES - 1)
                                                        : idx_sh[LUT_W-1:0];
    assign lab_term   = r_label ? 18'sd65536 : 18'sd0;
    assign g_full     = mul_p >>> 16;

    assign busy        = r_state != S_IDLE;
    assign o_valid     = r_state == S_DONE;
    assign o_score     = r_score;
    assign o_gradient  = r_grad;
    assign o_read_data = r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        in_we     = 1'b0;
        in_waddr  = crow_base + cnt_addr;
        in_wdata  = '0;
        in_raddr  = crow_base + cnt_addr;
        out_we    = 1'b0;
        out_waddr = trow_base + cnt_addr;
        out_wdata = '0;
        out_raddr = trow_base + cnt_addr;
        acc_we    = 1'b0;
        acc_wdata = '0;
        mul_a     = '0;
        mul_b     = '0;
        diff      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_TRAIN: n_state = S_DOT_RD;
                        OP_WRITE: n_state = S_WRITE;
                        OP_READ:  n_state = S_READ_RD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE: begin
                in_waddr  = crow_base + el_addr;
                out_waddr = crow_base + el_addr;
                in_wdata  = r_wval;
                out_wdata = r_wval;
                in_we     = el_ok && !r_msel;
                out_we    = el_ok && r_msel;
                n_state   = S_DONE;
            end
            S_READ_RD: begin
                in_raddr  = crow_base + el_addr;
                out_raddr = crow_base + el_addr;
                n_state   = S_READ_DAT;
            end
            S_READ_DAT: begin
                n_state = S_DONE;
            end
            S_DOT_RD: begin
                n_state = S_DOT_MUL;
            end
            S_DOT_MUL: begin
                mul_a   = MUL_A_W'($signed(in_rdata));
                mul_b   = MUL_B_W'($signed(out_rdata));
                n_state = cnt_end ? S_DOT_FIN : S_DOT_RD;
            end
            S_DOT_FIN: begin
                n_state = S_SIG;
            end
            S_SIG: begin
                n_state = S_LUT;
            end
            S_LUT: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                if (r_over) begin
                    diff = lab_term - 18'sd65536;
                end else if (r_under) begin
                    diff = lab_term;
                end else begin
                    diff = lab_term - $signed({2'b00, lut_data});
                end
                mul_a   = diff;
                mul_b   = $signed({1'b0, r_alpha});
                n_state = S_GRAD;
            end
            S_GRAD: begin
                n_state = S_U_RD;
            end
            S_U_RD: begin
                n_state = S_U_M1;
            end
            S_U_M1: begin
                mul_a   = MUL_A_W'(r_g);
                mul_b   = MUL_B_W'($signed(out_rdata));
                n_state = S_U_M2;
            end
            S_U_M2: begin
                acc_we    = 1'b1;
                acc_wdata = sat32(64'(r_acc) + 64'(mul_p >>> 12));
                mul_a     = MUL_A_W'(r_g);
                mul_b     = MUL_B_W'(r_wi);
                n_state   = S_U_WR;
            end
            S_U_WR: begin
                out_we    = 1'b1;
                out_wdata = sat16(64'(r_wo) + 64'(mul_p >>> 16));
                if (cnt_end) begin
                    n_state = r_last ? S_A_RD : S_DONE;
                end else begin
                    n_state = S_U_RD;
                end
            end
            S_A_RD: begin
                n_state = S_A_WR;
            end
            S_A_WR: begin
                in_we    = 1'b1;
                in_wdata = sat16(64'($signed(in_rdata)) + 64'(acc_rd_val >>> 4));
                n_state  = cnt_end ? S_DONE : S_A_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid <= '0;
        end else if (acc_we) begin
            r_acc_valid[r_cnt] <= 1'b1;
        end else if (r_state == S_A_WR && cnt_end) begin
            r_acc_valid <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_vld_rd <= r_acc_valid[r_cnt];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_op     <= i_op;
                    r_crow   <= i_context_row[ROW_W-1:0];
                    r_trow   <= i_target_row[ROW_W-1:0];
                    r_label  <= i_label;
                    r_last   <= i_last_of_context;
                    r_alpha  <= i_learning_rate;
                    r_msel   <= i_matrix_select;
                    r_el     <= i_element_index;
                    r_wval   <= i_write_value;
                    r_cnt    <= '0;
                    r_pv     <= 1'b0;
                    r_dot    <= '0;
                    r_score  <= '0;
                    r_grad   <= '0;
                    r_rd     <= '0;
                end
            end
            S_READ_DAT: begin
                if (el_ok) begin
                    r_rd <= r_msel ? $signed(out_rdata) : $signed(in_rdata);
                end
            end
            S_DOT_RD: begin
                if (r_pv) begin
                    r_dot <= r_dot + DOT_W'(mul_p);
                end
            end
            S_DOT_MUL: begin
                r_pv  <= 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            S_DOT_FIN: begin
                r_dot <= r_dot + DOT_W'(mul_p);
            end
            S_SIG: begin
                r_score    <= sat16(64'(r_dot >>> 12));
                r_over     <= r_dot > DOT_LIM;
                r_under    <= r_dot < -DOT_LIM;
                r_idx_prod <= IDXP_W'(dot_off[OFF_W-1:0]) * IDXP_W'(TABLE_SCALE);
            end
            S_GRAD: begin
                if (g_full > MUL_P_W'(65535)) begin
                    r_g <= 17'sd65535;
                end else if (g_full < -MUL_P_W'(65536)) begin
                    r_g <= -17'sd65536;
                end else begin
                    r_g <= g_full[16:0];
                end
                r_cnt <= '0;
            end
            S_U_M1: begin
                r_wi  <= $signed(in_rdata);
                r_wo  <= $signed(out_rdata);
                r_acc <= acc_rd_val;
            end
            S_U_WR: begin
                r_grad <= r_g;
                r_cnt  <= cnt_end ? '0 : r_cnt + 1'b1;
            end
            S_A_WR: begin
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a busy period");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy held after the result transfer");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!in_we && !out_we && !acc_we))
        else $error("memory write while idle");

    a_grad_train_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_op != OP_TRAIN) |-> (o_gradient == 17'sd0 && o_score == 16'sd0))
        else $error("training result on a non-training item");

endmodule
